### hdl/http_header_value_extractor_top_defines.svh
// ----------------------------------------------------------------------------
// HTTP header value extractor: assertion macros
// Shared macros for the concurrent checks of the extractor modules.
// ----------------------------------------------------------------------------
`ifndef HTTP_HEADER_VALUE_EXTRACTOR_TOP_DEFINES_SVH
`define HTTP_HEADER_VALUE_EXTRACTOR_TOP_DEFINES_SVH

// Condition in the same cycle implies consequence in the same cycle.
`define HHVE_ASSERT_SAME(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Condition in one cycle implies consequence in the next cycle.
`define HHVE_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### hdl/hhve_pkg.sv
// ----------------------------------------------------------------------------
// HTTP header value extractor package
// Result codes, register indexes, character constants and queue word type.
// ----------------------------------------------------------------------------
package hhve_pkg;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_FOUND = 2'd1,
      KIND_NONE  = 2'd2,
      KIND_TRUNC = 2'd3
   } kind_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int KEY_WORDS   = 4;
   localparam int KEY_BYTES   = 32;
   localparam int LEN_W       = 6;
   localparam int CAP_W       = 13;
   localparam int COUNT_W     = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_0     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_1     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_2     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_3     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALUE_CAPACITY = 3'd5;

   localparam logic [LEN_W-1:0]   KEY_LENGTH_RESET = 6'd1;
   localparam logic [CAP_W-1:0]   CAPACITY_RESET   = 13'd256;
   localparam logic [CAP_W-1:0]   CAPACITY_MAX     = 13'd4096;
   localparam logic [CAP_W-1:0]   CAPACITY_MIN     = 13'd2;
   localparam logic [COUNT_W-1:0] LIMIT_MAX        = 12'd4095;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   // One queue word carries all results of one header byte: up to two.
   typedef struct packed {
      logic [1:0] count;
      kind_type   kind_a;
      logic [7:0] byte_a;
      kind_type   kind_b;
   } entry_type;

   // Only A to Z fold to lower case.
   function automatic logic [7:0] fold(input logic [7:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         return c | CASE_BIT;
      end
      return c;
   endfunction

endpackage

### hdl/hhve_front.sv
// ----------------------------------------------------------------------------
// HTTP header value extractor: front end
// Holds the configuration, scans header bytes and queues their results.
// ----------------------------------------------------------------------------
module hhve_front #(
   parameter int MAX_KEY_BYTES = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [hhve_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hhve_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_text_byte,
   input  logic                               req_last_byte,
   input  logic                               q_full,
   output logic                               push,
   output hhve_pkg::entry_type                push_entry
);
   import hhve_pkg::*;

   localparam int KPOS_W = $clog2(MAX_KEY_BYTES + 1);
   localparam int KIDX_W = $clog2(KEY_BYTES);

   typedef enum logic [2:0] {
      PH_MATCH,
      PH_SKIP,
      PH_SPACE,
      PH_VALUE,
      PH_DONE
   } phase_type;

   logic [CSR_DATA_W-1:0] key_ff [KEY_WORDS];
   logic [LEN_W-1:0]      key_length_ff;
   logic [CAP_W-1:0]      capacity_ff;

   phase_type             phase_ff, phase_in;
   logic [KPOS_W-1:0]     kpos_ff, kpos_in;
   logic [COUNT_W-1:0]    vcount_ff, vcount_in;
   logic                  prev_cr_ff, prev_cr_in;
   logic                  only_cr_ff, only_cr_in;

   logic [KPOS_W-1:0]     klen;
   logic [COUNT_W-1:0]    limit;
   logic [KIDX_W-1:0]     kidx;
   logic [7:0]            key_sel;
   logic                  fire;
   logic                  first;
   entry_type             entry;

   assign req_ready = !q_full;
   assign fire      = req_valid && req_ready;
   assign push      = fire && (entry.count != 2'd0);
   assign push_entry = entry;

   // Effective key length and value limit after clamping.
   assign klen  = (key_length_ff > LEN_W'(MAX_KEY_BYTES)) ? KPOS_W'(MAX_KEY_BYTES)
                                                          : KPOS_W'(key_length_ff);
   assign limit = (capacity_ff > CAPACITY_MAX) ? LIMIT_MAX
                                               : COUNT_W'(capacity_ff - 13'd1);
   assign kidx    = KIDX_W'(kpos_ff);
   assign key_sel = key_ff[kidx[KIDX_W-1:3]][{kidx[2:0], 3'b000} +: 8];
   assign first   = (phase_ff == PH_MATCH) && (kpos_ff == '0);

   always_comb begin
      phase_in     = phase_ff;
      kpos_in      = kpos_ff;
      vcount_in    = vcount_ff;
      prev_cr_in   = prev_cr_ff;
      only_cr_in   = only_cr_ff;
      entry.count  = 2'd0;
      entry.kind_a = KIND_BYTE;
      entry.byte_a = 8'd0;
      entry.kind_b = KIND_FOUND;

      if (phase_in != PH_DONE && (klen == '0 || capacity_ff < CAPACITY_MIN)) begin
         entry.count  = 2'd1;
         entry.kind_a = KIND_NONE;
         phase_in     = PH_DONE;
      end

      if (phase_in == PH_MATCH || phase_in == PH_SKIP) begin
         if (req_text_byte == CHAR_NUL) begin
            entry.count  = 2'd1;
            entry.kind_a = KIND_NONE;
            phase_in     = PH_DONE;
         end else if (prev_cr_ff && req_text_byte == CHAR_LF) begin
            // An empty line closes the header block without a match.
            if (only_cr_ff) begin
               entry.count  = 2'd1;
               entry.kind_a = KIND_NONE;
               phase_in     = PH_DONE;
            end else begin
               phase_in   = PH_MATCH;
               kpos_in    = '0;
               vcount_in  = '0;
               prev_cr_in = 1'b0;
               only_cr_in = 1'b0;
            end
         end else begin
            only_cr_in = first && (req_text_byte == CHAR_CR);
            prev_cr_in = (req_text_byte == CHAR_CR);
            if (phase_in == PH_MATCH) begin
               if (kpos_ff < klen) begin
                  if (fold(req_text_byte) == fold(key_sel)) begin
                     kpos_in = kpos_ff + KPOS_W'(1);
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end else if (req_text_byte == CHAR_COLON) begin
                  phase_in = PH_SPACE;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
      end else if (phase_in == PH_SPACE || phase_in == PH_VALUE) begin
         if (!(phase_in == PH_SPACE &&
               (req_text_byte == CHAR_SPACE || req_text_byte == CHAR_TAB))) begin
            phase_in = PH_VALUE;
            if (req_text_byte == CHAR_NUL || req_text_byte == CHAR_CR ||
                req_text_byte == CHAR_LF) begin
               entry.count  = 2'd1;
               entry.kind_a = KIND_FOUND;
               phase_in     = PH_DONE;
            end else if (vcount_ff < limit) begin
               entry.count  = 2'd1;
               entry.kind_a = KIND_BYTE;
               entry.byte_a = req_text_byte;
               vcount_in    = vcount_ff + COUNT_W'(1);
            end else begin
               entry.count  = 2'd1;
               entry.kind_a = KIND_TRUNC;
               phase_in     = PH_DONE;
            end
         end
      end

      if (req_last_byte) begin
         if (phase_in != PH_DONE) begin
            if (entry.count == 2'd0) begin
               entry.kind_a = (phase_in == PH_SPACE || phase_in == PH_VALUE) ?
                              KIND_FOUND : KIND_NONE;
               entry.count  = 2'd1;
            end else begin
               entry.kind_b = (phase_in == PH_SPACE || phase_in == PH_VALUE) ?
                              KIND_FOUND : KIND_NONE;
               entry.count  = 2'd2;
            end
         end
         phase_in   = PH_MATCH;
         kpos_in    = '0;
         vcount_in  = '0;
         prev_cr_in = 1'b0;
         only_cr_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_ff[i] <= '0;
         end
         key_length_ff <= KEY_LENGTH_RESET;
         capacity_ff   <= CAPACITY_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_WORD_0:     key_ff[0] <= csr_data;
            CSR_KEY_WORD_1:     key_ff[1] <= csr_data;
            CSR_KEY_WORD_2:     key_ff[2] <= csr_data;
            CSR_KEY_WORD_3:     key_ff[3] <= csr_data;
            CSR_KEY_LENGTH:     key_length_ff <= csr_data[LEN_W-1:0];
            CSR_VALUE_CAPACITY: capacity_ff <= csr_data[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MATCH;
         kpos_ff    <= '0;
         vcount_ff  <= '0;
         prev_cr_ff <= 1'b0;
         only_cr_ff <= 1'b0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         kpos_ff    <= kpos_in;
         vcount_ff  <= vcount_in;
         prev_cr_ff <= prev_cr_in;
         only_cr_ff <= only_cr_in;
      end
   end

endmodule

### hdl/hhve_fifo.sv
// ----------------------------------------------------------------------------
// HTTP header value extractor: result queue
// Short queue of result words between the scanner and the output stage.
// ----------------------------------------------------------------------------
`include "http_header_value_extractor_top_defines.svh"

module hhve_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hhve_pkg::entry_type push_entry,
   input  logic                pop,
   output hhve_pkg::entry_type pop_entry,
   output logic                full,
   output logic                empty
);
   import hhve_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `HHVE_ASSERT_SAME(a_no_push_full, clock, reset, push, !full, "push into a full queue")
   `HHVE_ASSERT_SAME(a_no_pop_empty, clock, reset, pop, !empty, "pop from an empty queue")
   `HHVE_ASSERT_NEXT(a_count_grows, clock, reset, push && !pop,
                     count_ff == $past(count_ff) + CNT_W'(1), "queue count lost a word")

endmodule

### hdl/hhve_back.sv
// ----------------------------------------------------------------------------
// HTTP header value extractor: output stage
// Unpacks queued result words into single results on the output channel.
// ----------------------------------------------------------------------------
`include "http_header_value_extractor_top_defines.svh"

module hhve_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   output logic                pop,
   input  hhve_pkg::entry_type q_entry,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_value_byte,
   output logic                rsp_end_of_search
);
   import hhve_pkg::*;

   logic       valid_ff, valid_in;
   kind_type   kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic       pend_ff, pend_in;
   kind_type   pend_kind_ff, pend_kind_in;
   logic       slot_free;

   // The output register may reload in the cycle its word is taken.
   assign slot_free = !valid_ff || rsp_ready;
   assign pop       = slot_free && !pend_ff && !q_empty;

   always_comb begin
      valid_in     = valid_ff;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      pend_in      = pend_ff;
      pend_kind_in = pend_kind_ff;
      if (slot_free) begin
         if (pend_ff) begin
            valid_in = 1'b1;
            kind_in  = pend_kind_ff;
            byte_in  = 8'd0;
            pend_in  = 1'b0;
         end else if (!q_empty) begin
            valid_in     = 1'b1;
            kind_in      = q_entry.kind_a;
            byte_in      = q_entry.byte_a;
            pend_in      = (q_entry.count == 2'd2);
            pend_kind_in = q_entry.kind_b;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
      kind_ff      <= kind_in;
      byte_ff      <= byte_in;
      pend_kind_ff <= pend_kind_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_value_byte    = byte_ff;
   assign rsp_end_of_search = (kind_ff != KIND_BYTE);

   `HHVE_ASSERT_SAME(a_pend_has_first, clock, reset, pend_ff, valid_ff,
                     "second result waiting without a first one shown")
   `HHVE_ASSERT_SAME(a_status_no_byte, clock, reset, valid_ff && kind_ff != KIND_BYTE,
                     byte_ff == 8'd0, "status result carries a value byte")

endmodule

### hdl/http_header_value_extractor_top.sv
// ----------------------------------------------------------------------------
// HTTP header value extractor
// Finds one configured header in a header block and streams out its value.
// ----------------------------------------------------------------------------
// Usage: write the key words, key length and value capacity through the csr_
// port while the block is idle; csr_ready is always high. Header bytes enter
// on the req_ channel, one word per byte, with req_last_byte on the final
// byte of each block. Results leave on the rsp_ channel: value bytes, then
// one status word (found, not found or truncated) with end of search set.
// Throughput is one header byte per cycle while the result queue has room;
// the scanner state registers update on each accepted byte. A byte yields
// zero, one or two results; two occur only when the final byte of a block
// is also a value byte, and then the output register shows them in turn.
// A result passes through the queue, which the scanner writes when its byte
// is accepted, and then into the output register, which loads it from the
// queue when the register is free and no second result of a byte waits.
// If the receiver stalls, results collect in a four-word queue; req_ready
// drops only when that queue is full. Reset is synchronous and restores the
// register defaults and the line start state; no memory sweep is needed.
// ----------------------------------------------------------------------------
module http_header_value_extractor_top #(
   parameter int MAX_KEY_BYTES = 32,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hhve_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hhve_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_text_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_kind,
   output logic [7:0]                        rsp_value_byte,
   output logic                              rsp_end_of_search
);
   import hhve_pkg::*;

   logic      q_push;
   logic      q_pop;
   logic      q_full;
   logic      q_empty;
   entry_type q_in;
   entry_type q_out;

   assign csr_ready = 1'b1;

   hhve_front #(
      .MAX_KEY_BYTES(MAX_KEY_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .push          (q_push),
      .push_entry    (q_in)
   );

   hhve_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .pop_entry  (q_out),
      .full       (q_full),
      .empty      (q_empty)
   );

   hhve_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .pop               (q_pop),
      .q_entry           (q_out),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_value_byte    (rsp_value_byte),
      .rsp_end_of_search (rsp_end_of_search)
   );

endmodule

### tb/sv/header_lookup_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Header lookup checker
// Watches the register, header byte and result channels of the extractor,
// predicts the results of every accepted header byte and compares each
// accepted result word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module header_lookup_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [hhve_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hhve_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [7:0]                       req_text_byte,
   input  logic                             req_last_byte,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [1:0]                       rsp_kind,
   input  logic [7:0]                       rsp_value_byte,
   input  logic                             rsp_end_of_search,
   output int                               mismatch_count,
   output int                               awaited_count,
   output int                               header_bytes,
   output int                               value_bytes,
   output int                               found_count,
   output int                               missing_count,
   output int                               truncated_count,
   output int                               register_writes
);
   import hhve_pkg::*;

   typedef enum logic [2:0] {
      SCAN_MATCH,
      SCAN_SKIP,
      SCAN_SPACES,
      SCAN_VALUE,
      SCAN_DONE
   } scan_phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic       closes_search;
   } lookup_result_type;

   lookup_result_type awaited_results [$];
   lookup_result_type want;

   logic [CSR_DATA_W-1:0] key_words [KEY_WORDS];
   logic [LEN_W-1:0]      key_length;
   logic [CAP_W-1:0]      capacity;

   scan_phase_type     phase;
   logic [5:0]         key_pos;
   logic [COUNT_W-1:0] value_count;
   logic               prev_cr;
   logic               line_only_cr;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_BIT : c;
   endfunction

   function automatic logic [7:0] key_char(input logic [5:0] pos);
      return key_words[pos[4:3]][{pos[2:0], 3'b000} +: 8];
   endfunction

   task automatic await_result(input kind_type kind, input logic [7:0] value);
      awaited_results.push_back('{kind, value, kind != KIND_BYTE});
   endtask

   task automatic restart_line();
      phase        = SCAN_MATCH;
      key_pos      = '0;
      value_count  = '0;
      prev_cr      = 1'b0;
      line_only_cr = 1'b0;
   endtask

   task automatic scan_header_byte(input logic [7:0] b, input logic is_last);
      int   klen;
      int   cap;
      int   limit;
      logic at_start;
      klen  = (key_length > KEY_BYTES) ? KEY_BYTES : key_length;
      cap   = (capacity > CAPACITY_MAX) ? CAPACITY_MAX : capacity;
      limit = (cap >= CAPACITY_MIN) ? cap - 1 : 0;

      // An empty key or a capacity with no room answers at once.
      if (phase != SCAN_DONE && (klen == 0 || cap < CAPACITY_MIN)) begin
         await_result(KIND_NONE, CHAR_NUL);
         phase = SCAN_DONE;
      end

      if (phase == SCAN_MATCH || phase == SCAN_SKIP) begin
         at_start = (phase == SCAN_MATCH && key_pos == 0);
         if (b == CHAR_NUL) begin
            await_result(KIND_NONE, CHAR_NUL);
            phase = SCAN_DONE;
         end else if (prev_cr && b == CHAR_LF) begin
            // CR LF on a line that held nothing else closes the header block.
            if (line_only_cr) begin
               await_result(KIND_NONE, CHAR_NUL);
               phase = SCAN_DONE;
            end else begin
               restart_line();
            end
         end else begin
            line_only_cr = at_start && b == CHAR_CR;
            prev_cr      = (b == CHAR_CR);
            if (phase == SCAN_MATCH) begin
               if (key_pos < klen) begin
                  if (to_lower(b) == to_lower(key_char(key_pos))) begin
                     key_pos++;
                  end else begin
                     phase = SCAN_SKIP;
                  end
               end else if (b == CHAR_COLON) begin
                  phase = SCAN_SPACES;
               end else begin
                  phase = SCAN_SKIP;
               end
            end
         end
      end else if (phase == SCAN_SPACES || phase == SCAN_VALUE) begin
         if (!(phase == SCAN_SPACES && (b == CHAR_SPACE || b == CHAR_TAB))) begin
            phase = SCAN_VALUE;
            if (b == CHAR_NUL || b == CHAR_CR || b == CHAR_LF) begin
               await_result(KIND_FOUND, CHAR_NUL);
               phase = SCAN_DONE;
            end else if (value_count < limit) begin
               await_result(KIND_BYTE, b);
               value_count++;
            end else begin
               await_result(KIND_TRUNC, CHAR_NUL);
               phase = SCAN_DONE;
            end
         end
      end

      if (is_last) begin
         if (phase == SCAN_MATCH || phase == SCAN_SKIP) begin
            await_result(KIND_NONE, CHAR_NUL);
         end else if (phase == SCAN_SPACES || phase == SCAN_VALUE) begin
            await_result(KIND_FOUND, CHAR_NUL);
         end
         restart_line();
      end
   endtask

   task automatic check_result();
      if (awaited_results.size() == 0) begin
         $error("result word with nothing awaited: kind %0d, value 'h%02h", rsp_kind,
                rsp_value_byte);
         mismatch_count++;
      end else begin
         want = awaited_results.pop_front();
         if (rsp_kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
            mismatch_count++;
         end
         if (rsp_value_byte !== want.value) begin
            $error("value_byte: expected 'h%02h, got 'h%02h", want.value, rsp_value_byte);
            mismatch_count++;
         end
         if (rsp_end_of_search !== want.closes_search) begin
            $error("end_of_search: expected %0d, got %0d", want.closes_search,
                   rsp_end_of_search);
            mismatch_count++;
         end
         case (want.kind)
            KIND_BYTE:  value_bytes++;
            KIND_FOUND: found_count++;
            KIND_NONE:  missing_count++;
            default:    truncated_count++;
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (key_words[i]) key_words[i] = '0;
         key_length = KEY_LENGTH_RESET;
         capacity   = CAPACITY_RESET;
         restart_line();
         awaited_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result();
         end
         if (csr_valid && csr_ready) begin
            register_writes++;
            case (csr_index)
               CSR_KEY_WORD_0:     key_words[0] = csr_data;
               CSR_KEY_WORD_1:     key_words[1] = csr_data;
               CSR_KEY_WORD_2:     key_words[2] = csr_data;
               CSR_KEY_WORD_3:     key_words[3] = csr_data;
               CSR_KEY_LENGTH:     key_length = csr_data[LEN_W-1:0];
               CSR_VALUE_CAPACITY: capacity = csr_data[CAP_W-1:0];
               default:            ;
            endcase
         end
         if (req_valid && req_ready) begin
            header_bytes++;
            scan_header_byte(req_text_byte, req_last_byte);
         end
      end
      awaited_count = awaited_results.size();
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP header value extractor testbench
// Drives header blocks and register settings into the extractor under random
// idling on both channels, with one long receiver stall, and lets the
// header lookup checker predict and compare every result word.
// ----------------------------------------------------------------------------
module tb_top;
   import hhve_pkg::*;

   localparam int RANDOM_ITEMS    = 520;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 6;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int CONFIG_EVERY    = 14;
   localparam int HOLD_BLOCK      = 40;

   // Indexes past the last register; writes to them must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_7 = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_text_byte;
   logic                   req_last_byte;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [1:0]             rsp_kind;
   logic [7:0]             rsp_value_byte;
   logic                   rsp_end_of_search;

   int mismatches;
   int awaiting;
   int header_bytes;
   int value_bytes;
   int found_count;
   int missing_count;
   int truncated_count;
   int register_writes;

   int         idle_cycles = 0;
   bit         steady = 1'b0;
   int         hold_off_left = 0;
   int         random_bytes;
   int         key_eff;
   int         cap_eff;
   logic [7:0] key_chars [KEY_BYTES];
   logic [7:0] blk [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   http_header_value_extractor_top dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_value_byte    (rsp_value_byte),
      .rsp_end_of_search (rsp_end_of_search)
   );

   header_lookup_checker lookup_check (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_value_byte    (rsp_value_byte),
      .rsp_end_of_search (rsp_end_of_search),
      .mismatch_count    (mismatches),
      .awaited_count     (awaiting),
      .header_bytes      (header_bytes),
      .value_bytes       (value_bytes),
      .found_count       (found_count),
      .missing_count     (missing_count),
      .truncated_count   (truncated_count),
      .register_writes   (register_writes)
   );

   // Result receiver. A requested hold-off takes precedence over random stalls.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 17);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** http_header_value_extractor_top: FAILED **");
         $finish;
      end
   end

   function automatic logic [CSR_DATA_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] key_word(input int w);
      logic [CSR_DATA_W-1:0] word;
      for (int i = 0; i < 8; i++) word[8*i +: 8] = key_chars[8*w + i];
      return word;
   endfunction

   function automatic logic [7:0] name_char();
      case ($urandom_range(3))
         0:       return 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
         1:       return 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z)) | CASE_BIT;
         2:       return 8'($urandom_range("0", "9"));
         default: return "-";
      endcase
   endfunction

   function automatic logic [7:0] flip_case(input logic [7:0] c);
      if ((c | CASE_BIT) >= "a" && (c | CASE_BIT) <= "z") begin
         return c ^ CASE_BIT;
      end
      return c;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Unused upper bits of the length and capacity words carry random junk.
   task automatic load_registers(input int klen, input int cap);
      logic [CSR_DATA_W-1:0] data;
      write_reg(CSR_KEY_WORD_0, key_word(0));
      write_reg(CSR_KEY_WORD_1, key_word(1));
      write_reg(CSR_KEY_WORD_2, key_word(2));
      write_reg(CSR_KEY_WORD_3, key_word(3));
      data = rand64();
      data[LEN_W-1:0] = klen[LEN_W-1:0];
      write_reg(CSR_KEY_LENGTH, data);
      data = rand64();
      data[CAP_W-1:0] = cap[CAP_W-1:0];
      write_reg(CSR_VALUE_CAPACITY, data);
      key_eff = (klen > KEY_BYTES) ? KEY_BYTES : klen;
      cap_eff = (cap > CAPACITY_MAX) ? CAPACITY_MAX : cap;
   endtask

   task automatic random_key();
      foreach (key_chars[i]) begin
         key_chars[i] = ($urandom_range(99) < 90) ? name_char() :
                        8'($urandom_range(1, 255));
      end
   endtask

   task automatic set_key_text(input string s);
      random_key();
      for (int i = 0; i < s.len(); i++) key_chars[i] = s[i];
   endtask

   task automatic random_config();
      int r;
      int klen;
      int cap;
      random_key();
      r = $urandom_range(99);
      if (r < 4) klen = 0;
      else if (r < 80) klen = $urandom_range(1, 6);
      else if (r < 92) klen = $urandom_range(7, KEY_BYTES);
      else klen = $urandom_range(KEY_BYTES + 1, 63);
      r = $urandom_range(99);
      if (r < 4) cap = $urandom_range(0, 1);
      else if (r < 75) cap = $urandom_range(2, 10);
      else if (r < 93) cap = $urandom_range(11, 300);
      else cap = $urandom_range(CAPACITY_MAX + 1, 8191);
      load_registers(klen, cap);
   endtask

   // Drops valid, waits for every awaited result and lets the pipeline drain.
   task automatic settle();
      req_valid <= 1'b0;
      while (awaiting != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic is_last);
      if (!steady && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      req_last_byte <= is_last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_block();
      foreach (blk[i]) send_byte(blk[i], i == blk.size() - 1);
      random_bytes += blk.size();
      blk.delete();
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) blk.push_back(s[i]);
   endtask

   task automatic add_key_name(input int n);
      for (int i = 0; i < n; i++) begin
         blk.push_back($urandom_range(1) ? flip_case(key_chars[i]) : key_chars[i]);
      end
   endtask

   task automatic add_value(input int n);
      int r;
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 80) blk.push_back(8'($urandom_range(33, 126)));
         else if (r < 90) blk.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
         else blk.push_back(8'($urandom_range(255)));
      end
   endtask

   // Other header lines, often starting with part or all of the key.
   task automatic add_other_line();
      if (key_eff > 0 && $urandom_range(1)) add_key_name($urandom_range(1, key_eff));
      repeat ($urandom_range(1, 6)) blk.push_back(name_char());
      add_text(": ");
      add_value($urandom_range(0, 6));
      add_text("\r\n");
   endtask

   task automatic make_header_block();
      int r;
      int vmax;
      repeat ($urandom_range(0, 3)) add_other_line();
      if ($urandom_range(99) < 80) begin
         add_key_name(key_eff);
         blk.push_back(CHAR_COLON);
         repeat ($urandom_range(0, 3)) blk.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
         vmax = (cap_eff + 1 < 24) ? cap_eff + 1 : 24;
         add_value($urandom_range(0, vmax));
         r = $urandom_range(99);
         if (r < 70) add_text("\r\n");
         else if (r < 80) blk.push_back(CHAR_CR);
         else if (r < 90) blk.push_back(CHAR_LF);
      end
      repeat ($urandom_range(0, 2)) add_other_line();
      r = $urandom_range(99);
      if (r < 75) add_text("\r\n");
      else if (r < 85) blk.push_back(CHAR_NUL);
      // Broken blocks: the block ends somewhere in the middle.
      if ($urandom_range(99) < 15 && blk.size() > 1) begin
         r = $urandom_range(1, blk.size() - 1);
         while (blk.size() > r) void'(blk.pop_back());
      end
      if (blk.size() == 0) blk.push_back(name_char());
   endtask

   initial begin : stimulus
      int blocks;
      reset         = 1'b1;
      csr_valid     = 1'b0;
      csr_index     = CSR_KEY_WORD_0;
      csr_data      = '0;
      req_valid     = 1'b0;
      req_text_byte = CHAR_NUL;
      req_last_byte = 1'b0;
      random_bytes  = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_reg(CSR_SPARE_6, rand64());
      write_reg(CSR_SPARE_7, rand64());

      // One-letter key and room for two value bytes.
      set_key_text("K");
      load_registers(1, 3);
      add_text("k:\t xy");           // two results on the final byte
      send_block();
      add_text("K:xyz");             // truncated, rest ignored
      send_block();
      add_text("\r\nK");             // empty line ends the search
      send_block();
      add_text("k:");                // end of text right after the colon
      blk.push_back(CHAR_NUL);
      send_block();
      blk.push_back(CHAR_NUL);
      send_block();
      add_text("K");                 // block ends while matching
      send_block();
      add_text("kx\r\nK:");          // exact fill, then CR
      blk.push_back(8'hFF);
      blk.push_back(8'h80);
      blk.push_back(CHAR_CR);
      send_block();
      add_text("\rK:v");             // a lone CR does not start a new line
      send_block();

      settle();
      set_key_text("\r\nz");
      load_registers(3, 300);
      add_text("\r\nz:1");
      send_block();

      settle();
      load_registers(0, CAPACITY_RESET);
      add_text("K:a");
      send_block();
      settle();
      set_key_text("K");
      load_registers(1, 0);
      add_text("K");
      send_block();
      settle();
      load_registers(1, 1);
      add_text("K:");
      send_block();

      settle();
      random_key();
      load_registers(KEY_BYTES, 8191);
      add_key_name(KEY_BYTES);
      add_text(": ab\r\n");
      send_block();
      settle();
      load_registers(63, 20);
      add_key_name(KEY_BYTES);
      add_text(":");
      add_value(5);
      send_block();

      // Largest capacity with a short value.
      settle();
      set_key_text("K");
      load_registers(1, CAPACITY_MAX);
      add_text("K:");
      repeat (8) blk.push_back(8'($urandom_range(33, 126)));
      send_block();

      random_bytes = 0;
      blocks = 0;
      while (random_bytes < RANDOM_ITEMS) begin
         if (blocks % CONFIG_EVERY == 0) begin
            settle();
            random_config();
         end
         steady = (blocks >= 20 && blocks < 34);
         if (blocks == HOLD_BLOCK) begin
            // A long value while the receiver holds off fills the result queue.
            settle();
            foreach (key_chars[i]) key_chars[i] = name_char();
            load_registers(8, 64);
            add_key_name(8);
            add_text(": ");
            repeat (40) blk.push_back(8'($urandom_range(33, 126)));
            add_text("\r\n\r\n");
            steady = 1'b1;
            hold_off_left = HOLD_OFF_CYCLES;
            send_block();
            steady = 1'b0;
         end else begin
            if ($urandom_range(99) < 80) begin
               make_header_block();
            end else begin
               repeat ($urandom_range(1, 12)) blk.push_back(8'($urandom_range(255)));
            end
            send_block();
         end
         blocks++;
      end

      settle();
      $display("Run covered %0d header bytes and %0d register writes, giving", header_bytes,
               register_writes);
      $display("%0d value bytes, %0d found, %0d not found and %0d truncated searches.",
               value_bytes, found_count, missing_count, truncated_count);
      if (mismatches == 0 && awaiting == 0) begin
         $display("** http_header_value_extractor_top: PASSED **");
      end else begin
         $display("** http_header_value_extractor_top: FAILED **");
      end
      $finish;
   end

endmodule
